// ----- hw/rtl/adx_pkg.sv -----
// ----------------------------------------------------------------------------
// adx_pkg: shared types and constants of the Art-Net DMX channel extractor
// Holds the status codes, the register indexes, the header constants and
// the word type that the front end hands to the back end.
// ----------------------------------------------------------------------------
package adx_pkg;

  // Header layout and opcodes
  localparam int unsigned POS_W      = 11;
  localparam logic [POS_W-1:0] POS_MAX   = 11'd2047;
  localparam logic [POS_W-1:0] HDR_BYTES = 11'd18;
  localparam logic [POS_W-1:0] POS_OP_LO = 11'd8;
  localparam logic [POS_W-1:0] POS_OP_HI = 11'd9;
  localparam logic [POS_W-1:0] POS_UNIV  = 11'd14;
  localparam logic [POS_W-1:0] POS_LEN_HI = 11'd16;
  localparam logic [POS_W-1:0] POS_LEN_LO = 11'd17;
  localparam logic [15:0] OP_POLL = 16'h2000;
  localparam logic [15:0] OP_DMX  = 16'h5000;

  // Channel index wide enough for the largest channel count (eight)
  localparam int unsigned CH_IDX_W = 3;

  // Queue between front and back end
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBNET   = 2'd0,
    CFG_UNIVERSE = 2'd1,
    CFG_START    = 2'd2
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_APPLIED   = 3'd0,
    ST_OTHER_UNI = 3'd1,
    ST_POLL      = 3'd2,
    ST_OTHER_OP  = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_SHORT     = 3'd5
  } status_e;

  // Word moved from the front end to the back end
  typedef struct packed {
    logic                cap;
    logic [CH_IDX_W-1:0] ch;
    logic [7:0]          data;
    logic                commit;
    status_e             status;
  } adx_word_t;

  // Expected byte of the "Art-Net" id followed by a zero byte
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h41;
      3'd1:    r = 8'h72;
      3'd2:    r = 8'h74;
      3'd3:    r = 8'h2d;
      3'd4:    r = 8'h4e;
      3'd5:    r = 8'h65;
      3'd6:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/adx_front.sv -----
// ----------------------------------------------------------------------------
// adx_front: header parser and byte classifier
// Tracks the byte position, checks the id, gathers the opcode, universe and
// declared length, and turns each byte into a capture and/or commit word.
// ----------------------------------------------------------------------------
module adx_front
  import adx_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      subnet_i,
  input  logic [3:0]      universe_i,
  input  logic [9:0]      start_channel_i,
  input  logic            byte_valid_i,
  output logic            byte_ready_o,
  input  logic [7:0]      pkt_byte_i,
  input  logic            last_byte_i,
  output logic            push_o,
  output adx_word_t       word_o,
  input  logic            full_i
);

  logic [POS_W-1:0] pos_q;
  logic             id_good_q, id_good_d;
  logic [15:0]      opcode_q, opcode_d;
  logic             uni_match_q, uni_match_d;
  logic [15:0]      len_q, len_d;

  logic             accept;
  logic             data_zone;
  logic [POS_W-1:0] data_idx;
  logic [9:0]       first_ch;
  logic [POS_W-1:0] ch_off;
  logic             cap;
  status_e          status;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && !full_i;

  // Header field updates for the current byte
  always_comb begin
    id_good_d   = id_good_q;
    opcode_d    = opcode_q;
    uni_match_d = uni_match_q;
    len_d       = len_q;
    if (pos_q < POS_OP_LO) begin
      if (pkt_byte_i != id_byte(pos_q[2:0])) id_good_d = 1'b0;
    end
    if (pos_q == POS_OP_LO) opcode_d = {opcode_q[15:8], pkt_byte_i};
    if (pos_q == POS_OP_HI) opcode_d = {pkt_byte_i, opcode_q[7:0]};
    if (pos_q == POS_UNIV)  uni_match_d = (pkt_byte_i == {subnet_i, universe_i});
    if (pos_q == POS_LEN_HI) len_d = {pkt_byte_i, len_q[7:0]};
    if (pos_q == POS_LEN_LO) len_d = {len_q[15:8], pkt_byte_i};
  end

  // Data capture window: inside the declared length and the channel range
  assign data_zone = (pos_q >= HDR_BYTES) && (pos_q != POS_MAX);
  assign data_idx  = pos_q - HDR_BYTES;
  assign first_ch  = (start_channel_i == 10'd0) ? 10'd0 : start_channel_i - 10'd1;
  assign ch_off    = data_idx - {1'b0, first_ch};
  assign cap       = data_zone && (data_idx >= {1'b0, first_ch})
                     && ({5'd0, data_idx} < len_q)
                     && (ch_off < POS_W'(CHANNELS));

  // Packet status, evaluated with this byte's header updates folded in
  always_comb begin
    if (pos_q < POS_OP_HI)          status = ST_SHORT;
    else if (!id_good_d)            status = ST_BAD_ID;
    else if (opcode_d == OP_POLL)   status = ST_POLL;
    else if (opcode_d != OP_DMX)    status = ST_OTHER_OP;
    else if (pos_q < POS_LEN_LO)    status = ST_SHORT;
    else if (!uni_match_d)          status = ST_OTHER_UNI;
    else                            status = ST_APPLIED;
  end

  assign word_o.cap    = cap;
  assign word_o.ch     = ch_off[CH_IDX_W-1:0];
  assign word_o.data   = pkt_byte_i;
  assign word_o.commit = last_byte_i;
  assign word_o.status = status;
  assign push_o        = accept && (cap || last_byte_i);

  // Packet state registers, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      id_good_q   <= 1'b1;
      opcode_q    <= '0;
      uni_match_q <= 1'b0;
      len_q       <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        pos_q       <= '0;
        id_good_q   <= 1'b1;
        opcode_q    <= '0;
        uni_match_q <= 1'b0;
        len_q       <= '0;
      end else begin
        if (pos_q != POS_MAX) pos_q <= pos_q + POS_W'(1);
        id_good_q   <= id_good_d;
        opcode_q    <= opcode_d;
        uni_match_q <= uni_match_d;
        len_q       <= len_d;
      end
    end
  end

endmodule

// ----- hw/rtl/adx_queue.sv -----
// ----------------------------------------------------------------------------
// adx_queue: short word queue between front and back end
// A small circular buffer with a fill count; push and pop may happen in the
// same cycle.
// ----------------------------------------------------------------------------
module adx_queue
  import adx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  adx_word_t word_i,
  output logic      full_o,
  input  logic      pop_i,
  output adx_word_t word_o,
  output logic      empty_o
);

  adx_word_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;

  assign full_o  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign word_o  = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= word_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + (Q_PTR_W+1)'(1);
      else if (!push_i && pop_i) count_q <= count_q - (Q_PTR_W+1)'(1);
    end
  end

endmodule

// ----- hw/rtl/adx_back.sv -----
// ----------------------------------------------------------------------------
// adx_back: pending capture, duty commit and result register
// Collects captured channel bytes and, on a commit word, applies them to the
// duty registers and loads the result register.
// ----------------------------------------------------------------------------
module adx_back
  import adx_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  adx_word_t   word_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output status_e     status_o,
  output logic [31:0] duties_o,
  output logic [3:0]  changed_mask_o,
  output logic        start_pwm_o
);

  localparam int unsigned VIS  = (CHANNELS < 4) ? CHANNELS : 4;
  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]          pend_q [CHANNELS];
  logic [CHANNELS-1:0] pend_valid_q;
  logic [7:0]          duty_q [CHANNELS];
  logic [7:0]          duty_d [CHANNELS];
  logic [CHANNELS-1:0] mask;
  logic [31:0]         packed_duty;
  logic [CH_W-1:0]     ch_sel;

  logic    out_valid_q;
  status_e status_q;
  logic [31:0] duties_q;
  logic [3:0]  mask_q;
  logic        pwm_q;

  logic do_commit;

  // A commit waits for room in the result register; captures never wait
  assign pop_o     = !empty_i && (!word_i.commit || !out_valid_q || res_ready_i);
  assign do_commit = pop_o && word_i.commit;
  assign ch_sel    = word_i.ch[CH_W-1:0];

  // Merge this word's capture and compare against the duty registers
  always_comb begin
    logic       hit;
    logic       eff_valid;
    logic [7:0] eff;
    for (int c = 0; c < CHANNELS; c++) begin
      hit       = word_i.cap && (word_i.ch == CH_IDX_W'(c));
      eff_valid = pend_valid_q[c] || hit;
      eff       = hit ? word_i.data : pend_q[c];
      duty_d[c] = duty_q[c];
      mask[c]   = 1'b0;
      if (word_i.status == ST_APPLIED && eff_valid && eff != duty_q[c]) begin
        duty_d[c] = eff;
        mask[c]   = 1'b1;
      end
    end
  end

  // Only the first four channels are visible in the result
  always_comb begin
    packed_duty = '0;
    for (int c = 0; c < VIS; c++) packed_duty[8*c +: 8] = duty_d[c];
  end

  // Pending bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop_o && word_i.cap) pend_q[ch_sel] <= word_i.data;
  end

  // Pending valid bits and duty registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
      for (int c = 0; c < CHANNELS; c++) duty_q[c] <= '0;
    end else if (do_commit) begin
      pend_valid_q <= '0;
      for (int c = 0; c < CHANNELS; c++) duty_q[c] <= duty_d[c];
    end else if (pop_o && word_i.cap) begin
      pend_valid_q[ch_sel] <= 1'b1;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_commit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (do_commit) begin
      status_q <= word_i.status;
      duties_q <= packed_duty;
      mask_q   <= 4'(mask);
      pwm_q    <= |mask;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign duties_o       = duties_q;
  assign changed_mask_o = mask_q;
  assign start_pwm_o    = pwm_q;

endmodule

// ----- hw/rtl/artnet_dmx_channel_extractor.sv -----
// ----------------------------------------------------------------------------
// artnet_dmx_channel_extractor: Art-Net ArtDmx receiver for a few channels
// Parses an Art-Net payload byte stream, captures the channels selected by
// the start channel and commits them to duty registers at the packet end.
//
//   channel    dir  tdata                                   tuser / tlast
//   s_axis     in   [7:0] pkt_byte                          tlast: last_byte
//   m_axis     out  [31:0] duties [35:32] changed_mask      tuser: [2:0] status
//                   [36] start_pwm, [39:37] zero
//   cfg        in   cfg_idx_i 0 subnet, 1 universe, 2 start_channel
//
// One byte is taken per cycle while the queue has room; the front end
// classifies it in the cycle it arrives and the back end retires one queued
// word per cycle unless a commit waits. With an empty queue, the commit word
// of the last byte is queued, then sets m_axis_tvalid in the result register.
// Reset clears the packet state and the duty registers; no clearing pass.
// A stalled result register stops the queue at its next commit word, and
// s_axis_tready drops only when the four-entry queue is full.
// ----------------------------------------------------------------------------
module artnet_dmx_channel_extractor
  import adx_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Byte input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pkt_byte
  input  logic                  s_axis_tlast,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [31:0] duties, [35:32] changed_mask,
                                                // [36] start_pwm, [39:37] zero
  output logic [2:0]            m_axis_tuser    // [2:0] status
);

  logic [3:0] subnet_q;
  logic [3:0] universe_q;
  logic [9:0] start_q;

  logic      push, full, pop, empty;
  adx_word_t push_word, head_word;

  status_e     status;
  logic [31:0] duties;
  logic [3:0]  changed_mask;
  logic        start_pwm;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subnet_q   <= '0;
      universe_q <= '0;
      start_q    <= 10'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUBNET:   subnet_q   <= cfg_data_i[3:0];
        CFG_UNIVERSE: universe_q <= cfg_data_i[3:0];
        CFG_START:    start_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  adx_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .subnet_i       (subnet_q),
    .universe_i     (universe_q),
    .start_channel_i(start_q),
    .byte_valid_i   (s_axis_tvalid),
    .byte_ready_o   (s_axis_tready),
    .pkt_byte_i     (s_axis_tdata),
    .last_byte_i    (s_axis_tlast),
    .push_o         (push),
    .word_o         (push_word),
    .full_i         (full)
  );

  adx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .word_i (push_word),
    .full_o (full),
    .pop_i  (pop),
    .word_o (head_word),
    .empty_o(empty)
  );

  adx_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_i        (head_word),
    .empty_i       (empty),
    .pop_o         (pop),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .status_o      (status),
    .duties_o      (duties),
    .changed_mask_o(changed_mask),
    .start_pwm_o   (start_pwm)
  );

  // Result packing, lowest field first
  assign m_axis_tdata = {3'd0, start_pwm, changed_mask, duties};
  assign m_axis_tuser = status;

endmodule

// ----- tb/adx_result_checker.sv -----
// ----------------------------------------------------------------------------
// adx_result_checker: frame report predictor and checker
// Watches the configuration port and both streams of the Art-Net DMX channel
// extractor. It keeps its own copy of the registers, the header parse state
// and the duty registers. From every accepted byte word it predicts the frame
// report that the packet end causes, and it compares every report word that
// the block hands out with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adx_result_checker
  import adx_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pkt_byte
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [39:0]           m_axis_tdata,   // [31:0] duties, [35:32] changed_mask,
                                                // [36] start_pwm, [39:37] zero
  input  logic [2:0]            m_axis_tuser,   // [2:0] status
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    applied_o
);

  // One predicted frame report
  typedef struct packed {
    status_e     status;
    logic [31:0] duties;
    logic [3:0]  changed;
    logic        restart;
  } dmx_report_t;

  // The "Art-Net" id followed by a zero byte
  localparam logic [7:0] ART_NET_ID [8] = '{
    8'h41, 8'h72, 8'h74, 8'h2d, 8'h4e, 8'h65, 8'h74, 8'h00
  };

  // Channel index width for the pending arrays
  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  dmx_report_t frame_reports_q [$];

  // Register copies
  logic [3:0]  subnet_q;
  logic [3:0]  universe_q;
  logic [9:0]  start_q;

  // Packet parse state
  logic [10:0] pos_q;
  logic        id_ok_q;
  logic [15:0] opcode_q;
  logic        univ_hit_q;
  logic [15:0] dlen_q;
  logic [7:0]  pend_duty [CHANNELS];
  logic [CHANNELS-1:0] pend_valid;
  logic [7:0]  duty_q [CHANNELS];

  // Working values
  logic [10:0] data_idx;
  logic [10:0] first_ch;
  logic [10:0] out_ch;
  logic [7:0]  mask_all;
  int          total;
  dmx_report_t exp_r;
  dmx_report_t got_r;

  int fail_count = 0;
  int checked    = 0;
  int applied    = 0;

  assign fail_count_o = fail_count;
  assign checked_o    = checked;
  assign applied_o    = applied;

  // Compare one field; only the first few mismatches are printed.
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      if (fail_count < 10) begin
        $display("[%0t] report %0d mismatch in %s: expected %0h, actual %0h",
                 $realtime, checked, what, want, seen);
      end
      fail_count++;
    end
  endtask

  // Predict on byte words, compare on report words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subnet_q   = '0;
      universe_q = '0;
      start_q    = 10'd1;
      pos_q      = '0;
      id_ok_q    = 1'b1;
      opcode_q   = '0;
      univ_hit_q = 1'b0;
      dlen_q     = '0;
      pend_valid = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pend_duty[c] = '0;
        duty_q[c]    = '0;
      end
      frame_reports_q.delete();
      pending_o <= 0;
    end else begin
      // Register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SUBNET:   subnet_q   = cfg_data_i[3:0];
          CFG_UNIVERSE: universe_q = cfg_data_i[3:0];
          CFG_START:    start_q    = cfg_data_i;
          default: ;
        endcase
      end

      // Report words leaving the block
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_reports_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("[%0t] report word with none expected: status %0d tdata %h",
                     $realtime, m_axis_tuser, m_axis_tdata);
          end
          fail_count++;
        end else begin
          exp_r = frame_reports_q.pop_front();
          got_r.status  = status_e'(m_axis_tuser);
          got_r.duties  = m_axis_tdata[31:0];
          got_r.changed = m_axis_tdata[35:32];
          got_r.restart = m_axis_tdata[36];
          check_field("status", 32'(exp_r.status), 32'(got_r.status));
          check_field("duties", exp_r.duties, got_r.duties);
          check_field("changed_mask", 32'(exp_r.changed), 32'(got_r.changed));
          check_field("start_pwm", 32'(exp_r.restart), 32'(got_r.restart));
          check_field("padding", 32'd0, 32'(m_axis_tdata[39:37]));
          checked++;
        end
      end

      // Byte words entering the block
      if (s_axis_tvalid && s_axis_tready) begin
        if (pos_q < 11'd8) begin
          if (s_axis_tdata != ART_NET_ID[pos_q[2:0]]) id_ok_q = 1'b0;
        end else if (pos_q == POS_OP_LO) begin
          opcode_q[7:0] = s_axis_tdata;
        end else if (pos_q == POS_OP_HI) begin
          opcode_q[15:8] = s_axis_tdata;
        end else if (pos_q == POS_UNIV) begin
          univ_hit_q = (s_axis_tdata == {subnet_q, universe_q});
        end else if (pos_q == POS_LEN_HI) begin
          dlen_q[15:8] = s_axis_tdata;
        end else if (pos_q == POS_LEN_LO) begin
          dlen_q[7:0] = s_axis_tdata;
        end else if (pos_q >= HDR_BYTES && pos_q < POS_MAX) begin
          // A start channel of zero acts as one.
          data_idx = pos_q - HDR_BYTES;
          first_ch = (start_q == 10'd0) ? 11'd0 : 11'(start_q) - 11'd1;
          if (data_idx >= first_ch && 16'(data_idx) < dlen_q) begin
            out_ch = data_idx - first_ch;
            if (out_ch < 11'(CHANNELS)) begin
              pend_duty[out_ch[CH_W-1:0]]  = s_axis_tdata;
              pend_valid[out_ch[CH_W-1:0]] = 1'b1;
            end
          end
        end

        if (!s_axis_tlast) begin
          if (pos_q < POS_MAX) pos_q++;
        end else begin
          // Packet end: classify, commit and report.
          total = int'(pos_q) + 1;
          if (total < 10)                  exp_r.status = ST_SHORT;
          else if (!id_ok_q)               exp_r.status = ST_BAD_ID;
          else if (opcode_q == OP_POLL)    exp_r.status = ST_POLL;
          else if (opcode_q != OP_DMX)     exp_r.status = ST_OTHER_OP;
          else if (total < int'(HDR_BYTES)) exp_r.status = ST_SHORT;
          else if (!univ_hit_q)            exp_r.status = ST_OTHER_UNI;
          else                             exp_r.status = ST_APPLIED;

          mask_all = '0;
          if (exp_r.status == ST_APPLIED) begin
            applied++;
            for (int c = 0; c < CHANNELS; c++) begin
              if (pend_valid[c] && duty_q[c] != pend_duty[c]) begin
                duty_q[c]   = pend_duty[c];
                mask_all[c] = 1'b1;
              end
            end
          end
          exp_r.duties = '0;
          for (int c = 0; c < CHANNELS && c < 4; c++) begin
            exp_r.duties[8*c +: 8] = duty_q[c];
          end
          exp_r.changed = mask_all[3:0];
          exp_r.restart = (mask_all != '0);
          frame_reports_q.push_back(exp_r);

          pos_q      = '0;
          id_ok_q    = 1'b1;
          opcode_q   = '0;
          univ_hit_q = 1'b0;
          dlen_q     = '0;
          pend_valid = '0;
          for (int c = 0; c < CHANNELS; c++) pend_duty[c] = '0;
        end
      end

      pending_o <= frame_reports_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the Art-Net DMX channel extractor
// Feeds Art-Net payloads as byte words: a directed set of packets for every
// status, the header edges, the length bounds and the register extremes,
// then random packet mixes under several register settings. The result
// checker beside the block predicts and compares; this module drives
// traffic with bursty sending and a stalling receiver and prints the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import adx_pkg::*;

  localparam int unsigned CHANNELS     = 4;
  localparam int          RUN_LIMIT    = 400000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RANDOM_BYTES = 600;
  localparam int          RANDOM_PHASES = 6;

  typedef enum logic [1:0] {
    RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY
  } rx_mode_e;

  typedef enum logic [2:0] {
    PK_DMX, PK_POLL, PK_OTHER_OP, PK_BAD_ID, PK_SHORT, PK_NOISE
  } pkt_kind_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;   // [7:0] pkt_byte
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;         // [31:0] duties, [35:32] changed_mask,
                                               // [36] start_pwm, [39:37] zero
  logic [2:0]            m_axis_tuser;         // [2:0] status

  int fail_count;
  int reports_pending;
  int reports_checked;
  int frames_applied;

  // Stimulus bookkeeping
  logic [7:0] pkt_bytes [$];
  logic [3:0] cur_subnet;
  logic [3:0] cur_universe;
  logic [9:0] cur_start;
  int         burst_left    = 0;
  bit         quiet_sender  = 1'b0;
  int         sent_words    = 0;
  int         sent_packets  = 0;
  int         settings_used = 0;
  int         hold_requests = 0;
  int         cycle_count   = 0;
  int         phase_mark;

  artnet_dmx_channel_extractor #(
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  adx_result_checker #(
    .CHANNELS(CHANNELS)
  ) u_result_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (reports_pending),
    .checked_o    (reports_checked),
    .applied_o    (frames_applied)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("[%0t] run did not finish within %0d cycles", $realtime, RUN_LIMIT);
    $display("artnet_dmx_channel_extractor verification failed");
    $finish;
  end

  // Receiver: changing stall patterns, plus a long hold-off on request.
  initial begin
    rx_mode_e stall_mode;
    int       mode_left;
    int       hold_left;
    int       hold_seen;
    stall_mode = RX_ALWAYS;
    mode_left  = 0;
    hold_left  = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Data bytes lean on a small pool so that some duties repeat.
  function automatic logic [7:0] data_value();
    logic [7:0] v;
    case ($urandom_range(0, 4))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      2:       v = 8'($urandom_range(0, 3));
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  // Declared length around the number of data bytes actually sent.
  function automatic logic [15:0] pick_length(input int n);
    logic [15:0] len;
    case ($urandom_range(0, 4))
      0:       len = 16'(n);
      1:       len = 16'($urandom_range(0, n));
      2:       len = 16'hFFFF;
      3:       len = 16'($urandom);
      default: len = 16'(n + $urandom_range(1, 3));
    endcase
    return len;
  endfunction

  task automatic build_header(input logic [15:0] opcode, input logic [7:0] univ,
                              input logic [15:0] dlen);
    pkt_bytes.delete();
    for (int i = 0; i < 8; i++) pkt_bytes.push_back(id_byte(3'(i)));
    pkt_bytes.push_back(opcode[7:0]);
    pkt_bytes.push_back(opcode[15:8]);
    repeat (4) pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(univ);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(dlen[15:8]);
    pkt_bytes.push_back(dlen[7:0]);
  endtask

  task automatic build_dmx(input logic [7:0] univ, input int n, input logic [15:0] dlen);
    build_header(OP_DMX, univ, dlen);
    repeat (n) pkt_bytes.push_back(data_value());
  endtask

  task automatic truncate_to(input int len);
    while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
  endtask

  // Offer one word; the sender works in bursts with random gaps.
  task automatic send_word(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    sent_words++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
    sent_packets++;
  endtask

  // Wait for every report, then for the pipeline to go quiet.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (reports_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers while the block is idle.
  task automatic write_config(input logic [3:0] sub, input logic [3:0] uni,
                              input logic [9:0] start);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SUBNET;
    cfg_data_i <= 10'(sub);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_UNIVERSE;
    cfg_data_i <= 10'(uni);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_START;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_subnet   = sub;
    cur_universe = uni;
    cur_start    = start;
    settings_used++;
  endtask

  // Mostly well-formed ArtDmx with random content, the rest other kinds.
  task automatic random_packet();
    pkt_kind_e   kind;
    int          r;
    int          first;
    int          n;
    logic [7:0]  univ;
    logic [15:0] op;
    r = $urandom_range(0, 99);
    if (r < 60)      kind = PK_DMX;
    else if (r < 68) kind = PK_POLL;
    else if (r < 76) kind = PK_OTHER_OP;
    else if (r < 84) kind = PK_BAD_ID;
    else if (r < 92) kind = PK_SHORT;
    else             kind = PK_NOISE;
    univ  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : {cur_subnet, cur_universe};
    first = (cur_start == 10'd0) ? 0 : int'(cur_start) - 1;
    n     = $urandom_range(0, first + CHANNELS + 3);
    build_dmx(univ, n, pick_length(n));
    case (kind)
      PK_POLL: begin
        pkt_bytes[8] = OP_POLL[7:0];
        pkt_bytes[9] = OP_POLL[15:8];
        truncate_to($urandom_range(10, pkt_bytes.size()));
      end
      PK_OTHER_OP: begin
        op = 16'($urandom);
        if (op == OP_DMX || op == OP_POLL) op = op ^ 16'h0001;
        pkt_bytes[8] = op[7:0];
        pkt_bytes[9] = op[15:8];
      end
      PK_BAD_ID: begin
        r = $urandom_range(0, 7);
        pkt_bytes[r] = pkt_bytes[r] ^ 8'($urandom_range(1, 255));
      end
      PK_SHORT: truncate_to($urandom_range(1, 17));
      PK_NOISE: begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets under the reset-like setting
    write_config(4'd0, 4'd0, 10'd1);
    build_dmx(8'h00, 4, 16'd4);
    pkt_bytes[18] = 8'h11;
    pkt_bytes[19] = 8'h22;
    pkt_bytes[20] = 8'h33;
    pkt_bytes[21] = 8'h44;
    send_packet();
    // The same frame again changes nothing.
    send_packet();
    // Declared length cuts the capture short; extreme data values.
    build_dmx(8'h00, 6, 16'd2);
    pkt_bytes[18] = 8'h00;
    pkt_bytes[19] = 8'hFF;
    send_packet();
    // Received length cuts the capture short.
    build_dmx(8'h00, 1, 16'hFFFF);
    send_packet();
    build_dmx(8'h01, 4, 16'd4);
    send_packet();
    build_header(OP_POLL, 8'h00, 16'd0);
    send_packet();
    // Opcode with its bytes swapped is some other opcode.
    build_dmx(8'h00, 4, 16'd4);
    pkt_bytes[8] = OP_DMX[15:8];
    pkt_bytes[9] = OP_DMX[7:0];
    send_packet();
    build_dmx(8'h00, 4, 16'd4);
    pkt_bytes[7] = 8'h01;
    send_packet();
    // Under ten bytes the packet is too short, ahead of a bad id.
    build_dmx(8'h00, 4, 16'd4);
    pkt_bytes[2] = 8'h00;
    truncate_to(9);
    send_packet();
    build_dmx(8'h00, 4, 16'd4);
    truncate_to(10);
    send_packet();
    build_dmx(8'h00, 4, 16'd4);
    truncate_to(17);
    send_packet();
    build_header(OP_POLL, 8'h00, 16'd0);
    truncate_to(10);
    send_packet();
    build_dmx(8'h00, 0, 16'd0);
    send_packet();
    pkt_bytes.delete();
    pkt_bytes.push_back(8'h41);
    send_packet();
    wait_drained();

    // Highest subnet, universe and start channel; the data lies before the window.
    write_config(4'd15, 4'd15, 10'd512);
    build_dmx(8'hFF, 6, 16'd516);
    send_packet();
    build_dmx(8'hFF, 6, 16'd6);
    send_packet();
    wait_drained();

    // Start channel zero acts as one; swapped nibbles miss the universe.
    write_config(4'd5, 4'd10, 10'd0);
    build_dmx(8'h5A, 4, 16'd4);
    send_packet();
    build_dmx(8'hA5, 4, 16'd4);
    send_packet();
    wait_drained();

    // Widest start channel value
    write_config(4'd0, 4'd0, 10'd1023);
    build_dmx(8'h00, 6, 16'hFFFF);
    send_packet();
    wait_drained();

    // Receiver holds off while short packets pile up behind it.
    write_config(4'd3, 4'd12, 10'd2);
    quiet_sender = 1'b1;
    hold_requests++;
    repeat (12) begin
      pkt_bytes.delete();
      pkt_bytes.push_back(8'($urandom));
      send_packet();
    end
    repeat (3) begin
      build_dmx({4'd3, 4'd12}, 6, 16'd6);
      send_packet();
    end
    wait_drained();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_config(4'($urandom), 4'($urandom), 10'($urandom_range(0, 10)));
      quiet_sender = ($urandom_range(0, 3) == 0);
      phase_mark   = sent_words;
      while (sent_words - phase_mark < RANDOM_BYTES / RANDOM_PHASES) begin
        random_packet();
        send_packet();
      end
      wait_drained();
    end

    $display("Sent %0d byte words in %0d packets under %0d register settings.",
             sent_words, sent_packets, settings_used);
    $display("Compared %0d frame reports; %0d frames were applied to the duties.",
             reports_checked, frames_applied);
    if (fail_count == 0) begin
      $display("artnet_dmx_channel_extractor verification clean");
    end else begin
      $display("%0d mismatches counted", fail_count);
      $display("artnet_dmx_channel_extractor verification failed");
    end
    $finish;
  end

endmodule
